@@ design/gba_pkg.sv @@
// Shared types and constants for the gyro boxcar average with offset core.
// No dependencies; every other design file imports this package.
package gba_pkg;

	localparam int WINDOW    = 10;
	localparam int CAL_COUNT = 1000;

	localparam int SAMPLE_W = 16;
	localparam int RING_W   = 3 * SAMPLE_W;
	localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int TOTAL_W  = 20;
	localparam int SUM_W    = 26;
	localparam int CNT_W    = 10;
	localparam int MAG_W    = 25;
	localparam int RECIP_W  = MAG_W + 1;
	localparam int DIV_W    = 10;
	localparam int DIFF_W   = SAMPLE_W + 2;

	// Reciprocals scaled by 2^MAG_W; one compare and subtract corrects the quotient.
	localparam logic [RECIP_W-1:0] RECIP_WIN = RECIP_W'((2 ** MAG_W) / WINDOW);
	localparam logic [RECIP_W-1:0] RECIP_CAL = RECIP_W'((2 ** MAG_W) / CAL_COUNT);
	localparam logic [DIV_W-1:0]   DIV_WIN   = DIV_W'(WINDOW);
	localparam logic [DIV_W-1:0]   DIV_CAL   = DIV_W'(CAL_COUNT);

	// Configuration port.
	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_AVERAGE_ENABLE = 1'b0;

	localparam logic ACTION_MEASURE = 1'b0;
	localparam logic ACTION_CAL     = 1'b1;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_RAW,
		KIND_AVG,
		KIND_CAL,
		KIND_CAL_DONE
	} kind_t;

	typedef struct packed {
		logic                       action;
		logic signed [SAMPLE_W-1:0] rate_x;
		logic signed [SAMPLE_W-1:0] rate_y;
		logic signed [SAMPLE_W-1:0] rate_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] corrected_x;
		logic signed [SAMPLE_W-1:0] corrected_y;
		logic signed [SAMPLE_W-1:0] corrected_z;
		logic                       calibration_done;
	} out_beat_t;

	// Pipeline control shared by the three axis lanes.
	typedef struct packed {
		logic  adv;
		kind_t k_s1;
		kind_t k_s2;
		kind_t k_s3;
		kind_t k_s4;
		kind_t k_s5;
	} lane_ctl_t;

endpackage

@@ design/gyro_boxcar_average_with_offset_core.sv @@
// Top level of the gyro boxcar average with offset core.
// Depends on gba_pkg, gba_ring and gba_lane.
//
//  channel   direction  handshake                      beat
//  sample    in         sample_valid / sample_ready    gba_pkg::in_beat_t
//  result    out        result_valid / result_ready    gba_pkg::out_beat_t
//  config    in         APB write at psel&penable      average_enable at 0x0
//
// One beat is taken per cycle unless a result stalls; each passes stages one to five and the output register.
// The pace is set by the two-port ring memory, read at accept and written back
// when the beat leaves stage one, and by the pipelined reciprocal divider in each lane.
// Reset clears the ring valid bits, window totals, calibration sums and offsets.
// A stalled result freezes the whole pipeline, so sample_ready drops with it.
module gyro_boxcar_average_with_offset_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	output logic                         sample_ready,
	input  gba_pkg::in_beat_t            sample,
	output logic                         result_valid,
	input  logic                         result_ready,
	output gba_pkg::out_beat_t           result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gba_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import gba_pkg::*;

	// Configuration register: the user must write it only while the core is idle; the core does not enforce this.
	logic                 avg_en_q;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2 +: REG_IDX_W];
	assign prdata  = (reg_idx == REG_AVERAGE_ENABLE) ? {31'b0, avg_en_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_en_q <= 1'b1;
		end else if (psel && penable && pwrite && pready
				&& reg_idx == REG_AVERAGE_ENABLE) begin
			avg_en_q <= pwdata[0];
		end
	end

	// The whole pipeline moves together whenever the output register can take a beat.
	logic      adv;
	logic      accept;
	kind_t     kind_in;
	in_beat_t  samp_s1;
	kind_t     k_s1, k_s2, k_s3, k_s4, k_s5;
	kind_t     k_eff;
	logic [CNT_W-1:0] cal_cnt_q;
	logic [CNT_W-1:0] cnt_inc;
	logic      cal_hit;
	logic      out_valid_q;
	logic      cal_done_q;
	logic [RING_W-1:0] ring_old;
	lane_ctl_t ctl;

	assign adv          = !out_valid_q || result_ready;
	assign sample_ready = adv;
	assign accept       = sample_valid && adv;

	always_comb begin
		if (sample.action == ACTION_CAL) begin
			kind_in = KIND_CAL;
		end else if (avg_en_q) begin
			kind_in = KIND_AVG;
		end else begin
			kind_in = KIND_RAW;
		end
	end

	// The calibration counter is resolved in stage one, so a completing beat
	// is tagged before any lane sees it.
	assign cnt_inc = cal_cnt_q + 1'b1;
	assign cal_hit = (cnt_inc == CNT_W'(CAL_COUNT));
	assign k_eff   = (k_s1 == KIND_CAL && cal_hit) ? KIND_CAL_DONE : k_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_s1        <= KIND_NONE;
			k_s2        <= KIND_NONE;
			k_s3        <= KIND_NONE;
			k_s4        <= KIND_NONE;
			k_s5        <= KIND_NONE;
			cal_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			cal_done_q  <= 1'b0;
		end else if (adv) begin
			k_s1        <= accept ? kind_in : KIND_NONE;
			k_s2        <= k_eff;
			k_s3        <= k_s2;
			k_s4        <= k_s3;
			k_s5        <= k_s4;
			out_valid_q <= (k_s5 != KIND_NONE);
			cal_done_q  <= (k_s5 == KIND_CAL_DONE);
			if (k_s1 == KIND_CAL) begin
				cal_cnt_q <= cal_hit ? '0 : cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_s1 <= sample;
		end
	end

	// Ring read happens at accept, write back when the beat leaves stage one.
	gba_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.step    (accept && kind_in == KIND_AVG),
		.wr_en   (adv && k_s1 == KIND_AVG),
		.wr_data ({samp_s1.rate_z, samp_s1.rate_y, samp_s1.rate_x}),
		.rd_data (ring_old)
	);

	assign ctl = '{adv: adv, k_s1: k_eff, k_s2: k_s2, k_s3: k_s3, k_s4: k_s4, k_s5: k_s5};

	logic signed [SAMPLE_W-1:0] cx, cy, cz;

	gba_lane u_lane_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sample     (samp_s1.rate_x),
		.old_sample (ring_old[0 +: SAMPLE_W]),
		.corrected  (cx)
	);

	gba_lane u_lane_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sample     (samp_s1.rate_y),
		.old_sample (ring_old[SAMPLE_W +: SAMPLE_W]),
		.corrected  (cy)
	);

	gba_lane u_lane_z (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sample     (samp_s1.rate_z),
		.old_sample (ring_old[2*SAMPLE_W +: SAMPLE_W]),
		.corrected  (cz)
	);

	assign result_valid            = out_valid_q;
	assign result.corrected_x      = cx;
	assign result.corrected_y      = cy;
	assign result.corrected_z      = cz;
	assign result.calibration_done = cal_done_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_cnt_q < CNT_W'(CAL_COUNT))
		else $error("calibration counter passed its limit");
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !sample_ready)
		else $error("sample taken while result stalled");
	a_cal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.calibration_done) |->
		(result.corrected_x == '0 && result.corrected_y == '0
		&& result.corrected_z == '0))
		else $error("calibration beat carries nonzero rates");

endmodule

@@ design/gba_ring.sv @@
// Sample ring: WINDOW entries of three samples in a memory with a registered read.
// Depends on gba_pkg. Entries never written read back as zero through valid bits.
module gba_ring (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic                       step,
	input  logic                       wr_en,
	input  logic [gba_pkg::RING_W-1:0] wr_data,
	output logic [gba_pkg::RING_W-1:0] rd_data
);
	import gba_pkg::*;

	logic [RING_W-1:0] mem [WINDOW];
	logic [WINDOW-1:0] vld_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  rd_addr_q;
	logic [RING_W-1:0] rd_q;
	logic              rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[pos_q];
			end
			if (step) begin
				pos_q <= (pos_q == IDX_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
			end
			if (wr_en) begin
				vld_q[rd_addr_q] <= 1'b1;
			end
		end
	end

	// The write goes back to the entry read for the same item.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[rd_addr_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q      <= mem[pos_q];
			rd_addr_q <= pos_q;
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= IDX_W'(WINDOW - 1))
		else $error("ring position beyond window");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (rd_addr_q != pos_q))
		else $error("write back collides with next read entry");
	a_vld_set: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> vld_q[$past(rd_addr_q)])
		else $error("written entry not marked valid");

endmodule

@@ design/gba_lane.sv @@
// One axis lane: window total, calibration sum, constant division, offset and saturation.
// Depends on gba_pkg; stages are steered by the shared lane_ctl_t from the top level.
module gba_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gba_pkg::lane_ctl_t                ctl,
	input  logic signed [gba_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [gba_pkg::SAMPLE_W-1:0] old_sample,
	output logic signed [gba_pkg::SAMPLE_W-1:0] corrected
);
	import gba_pkg::*;

	logic signed [TOTAL_W-1:0]  total_q;
	logic signed [SUM_W-1:0]    cal_sum_q;
	logic signed [SAMPLE_W-1:0] offset_q;

	logic signed [TOTAL_W-1:0] total_nx;
	logic signed [SUM_W-1:0]   sum_nx;
	logic signed [SUM_W-1:0]   val_nx;

	logic signed [SUM_W-1:0] val_s2;
	logic                    neg_s3;
	logic [MAG_W-1:0]        mag_s3;
	logic [MAG_W-1:0]        q0_s4;
	logic [MAG_W-1:0]        mag_s4;
	logic                    neg_s4;
	logic signed [SUM_W-1:0] quo_s5;
	logic signed [SAMPLE_W-1:0] corrected_q;

	logic [SUM_W-1:0]         abs_s2;
	logic [RECIP_W-1:0]       recip;
	logic [MAG_W+RECIP_W-1:0] prod;
	logic [DIV_W-1:0]         divisor;
	logic [MAG_W+DIV_W-1:0]   qd;
	logic [MAG_W-1:0]         rem;
	logic [MAG_W-1:0]         q_fix;
	logic [MAG_W-1:0]         quo_mag;
	logic [SUM_W-1:0]         quo_ext;
	logic signed [DIFF_W-1:0] diff;
	logic signed [SAMPLE_W-1:0] sat;

	always_comb begin
		total_nx = total_q + TOTAL_W'(sample) - TOTAL_W'(old_sample);
		sum_nx   = cal_sum_q + SUM_W'(sample);
		case (ctl.k_s1)
			KIND_AVG:      val_nx = SUM_W'(total_nx);
			KIND_RAW:      val_nx = SUM_W'(sample);
			KIND_CAL_DONE: val_nx = sum_nx;
			default:       val_nx = '0;
		endcase
	end

	always_comb begin
		abs_s2  = val_s2[SUM_W-1] ? SUM_W'(-val_s2) : SUM_W'(val_s2);
		recip   = (ctl.k_s3 == KIND_AVG) ? RECIP_WIN : RECIP_CAL;
		prod    = mag_s3 * recip;
		divisor = (ctl.k_s4 == KIND_AVG) ? DIV_WIN : DIV_CAL;
		qd      = q0_s4 * divisor;
		rem     = mag_s4 - qd[MAG_W-1:0];
		q_fix   = (rem >= MAG_W'(divisor)) ? q0_s4 + 1'b1 : q0_s4;
		quo_mag = (ctl.k_s4 == KIND_RAW) ? mag_s4 : q_fix;
		quo_ext = {1'b0, quo_mag};
		diff    = DIFF_W'(signed'(quo_s5[SAMPLE_W:0])) - DIFF_W'(offset_q);
		if (diff > DIFF_W'(32767)) begin
			sat = 16'sh7fff;
		end else if (diff < -DIFF_W'(32768)) begin
			sat = 16'sh8000;
		end else begin
			sat = diff[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			cal_sum_q <= '0;
			offset_q  <= '0;
		end else if (ctl.adv) begin
			if (ctl.k_s1 == KIND_AVG) begin
				total_q <= total_nx;
			end
			if (ctl.k_s1 == KIND_CAL) begin
				cal_sum_q <= sum_nx;
			end else if (ctl.k_s1 == KIND_CAL_DONE) begin
				cal_sum_q <= '0;
			end
			if (ctl.k_s5 == KIND_CAL_DONE) begin
				offset_q <= quo_s5[SAMPLE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			val_s2 <= val_nx;
			neg_s3 <= val_s2[SUM_W-1];
			mag_s3 <= abs_s2[MAG_W-1:0];
			q0_s4  <= prod[MAG_W +: MAG_W];
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			quo_s5 <= neg_s4 ? signed'(-quo_ext) : signed'(quo_ext);
			if (ctl.k_s5 == KIND_RAW || ctl.k_s5 == KIND_AVG) begin
				corrected_q <= sat;
			end else begin
				corrected_q <= '0;
			end
		end
	end

	assign corrected = corrected_q;

endmodule

@@ tb/gyro_boxcar_average_with_offset_core_tb.sv @@
// Self-checking testbench for the gyro boxcar average with offset core.
// Depends on gba_pkg and gyro_boxcar_average_with_offset_core, and through it on gba_ring and gba_lane.
`timescale 1ns / 1ps

module gyro_boxcar_average_with_offset_core_tb;
	import gba_pkg::*;

	// Covers the pipeline latency, with some margin, before a config write or the end.
	localparam int SETTLE_CYCLES = 12;
	// Longest legal stretch without a beat is the HOLD_OFF result hold-off.
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_OFF      = 80;
	localparam int MAX_REPORTS   = 40;

	localparam logic [PADDR_W-1:0] ADDR_AVERAGE_ENABLE = PADDR_W'(4 * REG_AVERAGE_ENABLE);
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED       = PADDR_W'(4 * (REG_AVERAGE_ENABLE + 1));

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	in_beat_t    sample_beat  = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	out_beat_t   result_beat;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr  = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	gyro_boxcar_average_with_offset_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample_beat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_beat),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor state: our own copy of the filter, the calibration and the
	// average_enable register, advanced once per accepted sample beat.
	// ------------------------------------------------------------------
	logic signed [SAMPLE_W-1:0] ring_x [WINDOW];
	logic signed [SAMPLE_W-1:0] ring_y [WINDOW];
	logic signed [SAMPLE_W-1:0] ring_z [WINDOW];
	int  ring_slot = 0;
	int  total_x = 0, total_y = 0, total_z = 0;
	int  cal_acc_x = 0, cal_acc_y = 0, cal_acc_z = 0;
	int  cal_taken = 0;
	logic signed [SAMPLE_W-1:0] bias_x = '0, bias_y = '0, bias_z = '0;
	bit  averaging_on = 1'b1;

	out_beat_t corrected_queue [$];

	// Run statistics.
	int beats_sent      = 0;
	int cal_beats       = 0;
	int results_checked = 0;
	int cal_completions = 0;
	int clamped_outputs = 0;
	int input_stalls    = 0;
	int mismatches      = 0;

	// Idling knobs, in percent of cycles, and the receiver hold-off request.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_request   = 0;

	initial begin
		for (int i = 0; i < WINDOW; i++) begin
			ring_x[i] = '0;
			ring_y[i] = '0;
			ring_z[i] = '0;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] clamp_rate(input int v);
		if (v > 32767) begin
			clamped_outputs++;
			return 16'sh7FFF;
		end
		if (v < -32768) begin
			clamped_outputs++;
			return 16'sh8000;
		end
		return SAMPLE_W'(v);
	endfunction

	// Advances the predictor by one sample beat and returns the result it must cause.
	function automatic out_beat_t predict_correction(input in_beat_t b);
		out_beat_t r;
		int vx, vy, vz;
		r = '0;
		if (b.action == ACTION_CAL) begin
			cal_beats++;
			cal_acc_x += b.rate_x;
			cal_acc_y += b.rate_y;
			cal_acc_z += b.rate_z;
			cal_taken++;
			if (cal_taken >= CAL_COUNT) begin
				// Integer division truncates toward zero, as the offsets must.
				bias_x = SAMPLE_W'(cal_acc_x / CAL_COUNT);
				bias_y = SAMPLE_W'(cal_acc_y / CAL_COUNT);
				bias_z = SAMPLE_W'(cal_acc_z / CAL_COUNT);
				cal_acc_x = 0;
				cal_acc_y = 0;
				cal_acc_z = 0;
				cal_taken = 0;
				r.calibration_done = 1'b1;
			end
			return r;
		end
		if (averaging_on) begin
			// Empty slots hold zero, so a partly filled ring still divides by WINDOW.
			total_x += b.rate_x - ring_x[ring_slot];
			total_y += b.rate_y - ring_y[ring_slot];
			total_z += b.rate_z - ring_z[ring_slot];
			ring_x[ring_slot] = b.rate_x;
			ring_y[ring_slot] = b.rate_y;
			ring_z[ring_slot] = b.rate_z;
			ring_slot = (ring_slot + 1) % WINDOW;
			vx = total_x / WINDOW;
			vy = total_y / WINDOW;
			vz = total_z / WINDOW;
		end else begin
			// Raw mode leaves the ring and the totals alone.
			vx = b.rate_x;
			vy = b.rate_y;
			vz = b.rate_z;
		end
		r.corrected_x = clamp_rate(vx - bias_x);
		r.corrected_y = clamp_rate(vy - bias_y);
		r.corrected_z = clamp_rate(vz - bias_z);
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// Result side: random or held-off ready, and the scoreboard check.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		int hold_left;
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && result_valid && result_ready) begin
			if (corrected_queue.size() == 0) begin
				flag_mismatch($sformatf("result beat %h with nothing expected", result_beat));
			end else begin
				want = corrected_queue.pop_front();
				results_checked++;
				if (want.calibration_done)
					cal_completions++;
				if (result_beat.corrected_x !== want.corrected_x)
					flag_mismatch($sformatf("result %0d corrected_x got %0d want %0d",
						results_checked, result_beat.corrected_x, want.corrected_x));
				if (result_beat.corrected_y !== want.corrected_y)
					flag_mismatch($sformatf("result %0d corrected_y got %0d want %0d",
						results_checked, result_beat.corrected_y, want.corrected_y));
				if (result_beat.corrected_z !== want.corrected_z)
					flag_mismatch($sformatf("result %0d corrected_z got %0d want %0d",
						results_checked, result_beat.corrected_z, want.corrected_z));
				if (result_beat.calibration_done !== want.calibration_done)
					flag_mismatch($sformatf("result %0d calibration_done got %b want %b",
						results_checked, result_beat.calibration_done,
						want.calibration_done));
			end
		end
	end

	// Watchdog: ends the run if no beat moves on either channel for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (sample_valid && !sample_ready)
				input_stalls++;
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Timeout after %0d cycles without a beat", STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------

	// Offers one sample beat, with a random gap first, and records its expectation.
	task automatic send_sample(input in_beat_t beat);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sample_valid <= 1'b1;
		sample_beat  <= beat;
		do @(posedge clk); while (!sample_ready);
		beats_sent++;
		corrected_queue.push_back(predict_correction(beat));
	endtask

	task automatic send_rates(input logic action, input logic signed [SAMPLE_W-1:0] x,
			input logic signed [SAMPLE_W-1:0] y, input logic signed [SAMPLE_W-1:0] z);
		in_beat_t b;
		b.action = action;
		b.rate_x = x;
		b.rate_y = y;
		b.rate_z = z;
		send_sample(b);
	endtask

	// Lets every expected result come out, then lets the pipeline settle.
	task automatic quiesce_block();
		sample_valid <= 1'b0;
		while (corrected_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// Only bit 0 of average_enable is kept; other addresses are ignored.
		if (addr == ADDR_AVERAGE_ENABLE)
			averaging_on = data[0];
	endtask

	task automatic check_register();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_AVERAGE_ENABLE;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'b0, averaging_on})
			flag_mismatch($sformatf("average_enable read %h want %0d", prdata, averaging_on));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mix of full-range values, corner values and small values near zero.
	function automatic logic signed [SAMPLE_W-1:0] pick_rate();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(4))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return -16'sd1;
					3: return 16'sd1;
					default: return '0;
				endcase
			end
			1: return SAMPLE_W'(int'($urandom_range(200)) - 100);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] near_bias(input int center);
		return SAMPLE_W'(center + int'($urandom_range(1000)) - 500);
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Averaging from reset: a partly filled ring, then a ring full of each extreme, then two calibration beats.
	task automatic test_window_extremes();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_rates(ACTION_MEASURE, 16'sh7FFF, 16'sh8000, 16'sd0);
		send_rates(ACTION_MEASURE, -16'sd1, 16'sd1, 16'sh7FFF);
		send_rates(ACTION_MEASURE, 16'sh8000, 16'sh7FFF, -16'sd1);
		repeat (WINDOW) send_rates(ACTION_MEASURE, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
		repeat (WINDOW) send_rates(ACTION_MEASURE, 16'sh8000, 16'sh7FFF, 16'sh8000);
		send_rates(ACTION_CAL, 16'sh7FFF, 16'sh8000, 16'sd0);
		send_rates(ACTION_CAL, 16'sh8000, 16'sh7FFF, -16'sd1);
		quiesce_block();
	endtask

	// Raw pass-through, ignored writes, the kept low bit and read-back.
	task automatic test_raw_mode();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_register(ADDR_AVERAGE_ENABLE, 32'h0000_0000);
		check_register();
		send_rates(ACTION_MEASURE, 16'sh7FFF, 16'sh8000, 16'sd1);
		send_rates(ACTION_MEASURE, 16'sh8000, 16'sh7FFF, -16'sd1);
		quiesce_block();
		write_register(ADDR_UNMAPPED, 32'hFFFF_FFFF);
		write_register(ADDR_AVERAGE_ENABLE, 32'hFFFF_FFFE);
		check_register();
		send_rates(ACTION_MEASURE, 16'sh1234, -16'sh1234, 16'sh0F0F);
		quiesce_block();
		write_register(ADDR_AVERAGE_ENABLE, 32'h0000_0003);
		check_register();
		// The ring must have kept its contents across the raw beats.
		send_rates(ACTION_MEASURE, 16'sd0, 16'sd0, 16'sd0);
		quiesce_block();
		write_register(ADDR_AVERAGE_ENABLE, 32'hFFFF_FFFF);
	endtask

	// Completes one calibration with x and y samples near the given centers, with
	// measure beats mixed in; they must not disturb the sums.
	task automatic run_calibration(input int center_x, input int center_y,
			input int send_pct, input int recv_pct);
		int remaining;
		in_beat_t b;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		remaining = CAL_COUNT - cal_taken;
		while (remaining > 0) begin
			if ($urandom_range(9) == 0) begin
				b.action = ACTION_MEASURE;
				b.rate_x = pick_rate();
				b.rate_y = pick_rate();
				b.rate_z = pick_rate();
			end else begin
				b.action = ACTION_CAL;
				b.rate_x = near_bias(center_x);
				b.rate_y = near_bias(center_y);
				b.rate_z = SAMPLE_W'($urandom);
				remaining--;
			end
			send_sample(b);
		end
		quiesce_block();
	endtask

	// With large offsets in place, corner samples on x and y must clamp in both modes.
	task automatic test_saturation();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_register(ADDR_AVERAGE_ENABLE, 32'h0);
		send_rates(ACTION_MEASURE, 16'sh8000, 16'sh7FFF, 16'sh8000);
		send_rates(ACTION_MEASURE, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
		quiesce_block();
		write_register(ADDR_AVERAGE_ENABLE, 32'h1);
		repeat (WINDOW) send_rates(ACTION_MEASURE, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
		repeat (WINDOW) send_rates(ACTION_MEASURE, 16'sh7FFF, 16'sh8000, 16'sh8000);
		quiesce_block();
	endtask

	task automatic run_random(input int count, input bit avg_mode,
			input int send_pct, input int recv_pct);
		in_beat_t b;
		write_register(ADDR_AVERAGE_ENABLE, {31'b0, avg_mode});
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) begin
			b.action = ($urandom_range(3) == 0) ? ACTION_CAL : ACTION_MEASURE;
			b.rate_x = pick_rate();
			b.rate_y = pick_rate();
			b.rate_z = pick_rate();
			send_sample(b);
		end
		quiesce_block();
	endtask

	// The receiver holds off for a long stretch while beats keep coming, so the
	// pipeline fills and sample_ready has to drop.
	task automatic test_backpressure();
		in_beat_t b;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = HOLD_OFF;
		repeat (40) begin
			b.action = ACTION_MEASURE;
			b.rate_x = pick_rate();
			b.rate_y = pick_rate();
			b.rate_z = pick_rate();
			send_sample(b);
		end
		quiesce_block();
	endtask

	// ------------------------------------------------------------------
	// Sequence of tests.
	// ------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_register();
		test_window_extremes();
		test_raw_mode();
		run_random(50, 1'b1, 0, 0);
		run_random(50, 1'b0, 59, 0);
		run_random(50, 1'b1, 0, 59);
		run_random(50, 1'b1, 26, 26);
		test_backpressure();
		// A full calibration needs CAL_COUNT calibration beats, so it dominates the count.
		run_calibration(32000, -32000, 26, 26);
		test_saturation();

		quiesce_block();
		$display("Covered %0d sample beats (%0d calibration), %0d completed calibrations,",
			beats_sent, cal_beats, cal_completions);
		$display("%0d clamped outputs, %0d input stall cycles, %0d results checked.",
			clamped_outputs, input_stalls, results_checked);
		if (mismatches == 0 && corrected_queue.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, corrected_queue.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/gba_pkg.sv
design/gba_ring.sv
design/gba_lane.sv
design/gyro_boxcar_average_with_offset_core.sv
tb/gyro_boxcar_average_with_offset_core_tb.sv
